// File: src/lkvt_pkg.sv
package lkvt_pkg;

	localparam int MODE_W = 3;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_OUT_W = 7;
	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOOKUP = 3'd0,
		MODE_ACCESS = 3'd1,
		MODE_WRITE  = 3'd2,
		MODE_ERASE  = 3'd3,
		MODE_CLEAR  = 3'd4
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		WR_FOUND,
		WR_APPEND,
		WR_SHIFT
	} wr_sel_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_HIT,
		RES_APPEND,
		RES_MISS,
		RES_FULL,
		RES_CLEAR,
		RES_NOP
	} res_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_CMP,
		S_FOUND,
		S_MISS,
		S_SH_RD,
		S_SH_WR,
		S_FINISH
	} fsm_t;

	typedef struct packed {
		logic     load;
		logic     idx_inc;
		logic     rd_en;
		logic     rd_next;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     cnt_clr;
		res_sel_t res;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  match;
		logic  last;
		logic  shift_last;
		logic  cnt_zero;
		logic  cnt_full;
		logic  out_free;
	} dp_sts_t;

endpackage

// File: src/lkvt_ram.sv
module lkvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/lkvt_ctrl.sv
module lkvt_ctrl
	import lkvt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	fsm_t state_q, state_nxt;
	logic is_search;

	always_comb begin
		unique case (sts.mode)
			MODE_LOOKUP, MODE_ACCESS, MODE_WRITE, MODE_ERASE: is_search = 1'b1;
			default: is_search = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_nxt = S_DECODE;
			end
			S_DECODE: begin
				if (!is_search) state_nxt = S_FINISH;
				else if (sts.cnt_zero) state_nxt = S_MISS;
				else state_nxt = S_READ;
			end
			S_READ: state_nxt = S_CMP;
			S_CMP: begin
				priority if (sts.match) state_nxt = S_FOUND;
				else if (sts.last) state_nxt = S_MISS;
				else state_nxt = S_READ;
			end
			S_FOUND: begin
				if (sts.mode == MODE_ERASE && !sts.last) state_nxt = S_SH_RD;
				else state_nxt = S_FINISH;
			end
			S_MISS: state_nxt = S_FINISH;
			S_SH_RD: state_nxt = S_SH_WR;
			S_SH_WR: begin
				if (sts.shift_last) state_nxt = S_FINISH;
				else state_nxt = S_SH_RD;
			end
			S_FINISH: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.wr_sel = WR_FOUND;
		cmd.res = RES_NONE;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_DECODE: begin
				if (sts.mode == MODE_CLEAR) begin
					cmd.res = RES_CLEAR;
					cmd.cnt_clr = 1'b1;
				end else if (!is_search) begin
					cmd.res = RES_NOP;
				end
			end
			S_READ: cmd.rd_en = 1'b1;
			S_CMP: begin
				if (!sts.match && !sts.last) cmd.idx_inc = 1'b1;
			end
			S_FOUND: begin
				unique case (sts.mode)
					MODE_LOOKUP, MODE_ACCESS: cmd.res = RES_HIT;
					MODE_WRITE: begin
						cmd.res = RES_HIT;
						cmd.wr_en = 1'b1;
						cmd.wr_sel = WR_FOUND;
					end
					MODE_ERASE: begin
						cmd.res = RES_HIT;
						cmd.cnt_dec = sts.last;
					end
					default: cmd.res = RES_NONE;
				endcase
			end
			S_MISS: begin
				unique case (sts.mode)
					MODE_LOOKUP, MODE_ERASE: cmd.res = RES_MISS;
					MODE_ACCESS, MODE_WRITE: begin
						if (sts.cnt_full) begin
							cmd.res = RES_FULL;
						end else begin
							cmd.res = RES_APPEND;
							cmd.wr_en = 1'b1;
							cmd.wr_sel = WR_APPEND;
							cmd.cnt_inc = 1'b1;
						end
					end
					default: cmd.res = RES_NONE;
				endcase
			end
			S_SH_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_next = 1'b1;
			end
			S_SH_WR: begin
				// move slot idx+1 down into slot idx
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				cmd.idx_inc = 1'b1;
				cmd.cnt_dec = sts.shift_last;
			end
			S_FINISH: cmd.out_load = sts.out_free;
			default: cmd.load = 1'b0;
		endcase
	end

endmodule

// File: src/lkvt_dp.sv
module lkvt_dp
	import lkvt_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_BITS + VALUE_BITS;

	logic [63:0]           key_wide, val_wide, rd_wide;
	logic [15:0]           cnt_wide;
	logic [MODE_W-1:0]     mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [AW-1:0]         idx_q;
	logic [CW-1:0]         count_q;
	logic [VALUE_BITS-1:0] res_rd_q;
	logic                  res_hit_q;
	status_t               res_st_q;
	logic                  out_valid_q;
	logic [VAL_W-1:0]      out_rd_q;
	logic                  out_hit_q;
	status_t               out_st_q;
	logic [CNT_OUT_W-1:0]  out_cnt_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [EW-1:0]         ram_wdata, ram_rdata;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val, app_val;
	logic                  is_write;

	assign key_wide = {32'd0, s_tdata[KEY_W-1:0]};
	assign val_wide = {32'd0, s_tdata[KEY_W+VAL_W-1:KEY_W]};

	assign rd_key = ram_rdata[KEY_BITS-1:0];
	assign rd_val = ram_rdata[EW-1:KEY_BITS];
	assign is_write = (mode_q == MODE_WRITE);
	assign app_val = is_write ? val_q : '0;

	// stored word: value above key
	always_comb begin
		ram_we = cmd.wr_en;
		unique case (cmd.wr_sel)
			WR_FOUND: begin
				ram_waddr = idx_q;
				ram_wdata = {val_q, key_q};
			end
			WR_APPEND: begin
				ram_waddr = count_q[AW-1:0];
				ram_wdata = {app_val, key_q};
			end
			WR_SHIFT: begin
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
			end
		endcase
	end

	assign ram_raddr = cmd.rd_next ? idx_q + AW'(1) : idx_q;

	lkvt_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= s_tuser[MODE_W-1:0];
			key_q <= key_wide[KEY_BITS-1:0];
			val_q <= val_wide[VALUE_BITS-1:0];
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.res)
			RES_HIT: begin
				res_rd_q <= is_write ? val_q : rd_val;
				res_hit_q <= 1'b1;
				res_st_q <= STAT_OK;
			end
			RES_APPEND: begin
				res_rd_q <= app_val;
				res_hit_q <= 1'b0;
				res_st_q <= STAT_OK;
			end
			RES_MISS: begin
				res_rd_q <= '0;
				res_hit_q <= 1'b0;
				res_st_q <= STAT_NOT_FOUND;
			end
			RES_FULL: begin
				res_rd_q <= '0;
				res_hit_q <= 1'b0;
				res_st_q <= STAT_FULL;
			end
			RES_CLEAR: begin
				res_rd_q <= '0;
				res_hit_q <= 1'b0;
				res_st_q <= sts.cnt_zero ? STAT_EMPTY : STAT_OK;
			end
			RES_NOP: begin
				res_rd_q <= '0;
				res_hit_q <= 1'b0;
				res_st_q <= STAT_OK;
			end
			default: begin
				res_rd_q <= res_rd_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			priority if (cmd.cnt_clr) count_q <= '0;
			else if (cmd.cnt_inc) count_q <= count_q + CW'(1);
			else if (cmd.cnt_dec) count_q <= count_q - CW'(1);
		end
	end

	assign rd_wide = 64'(res_rd_q);
	assign cnt_wide = 16'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rd_q <= rd_wide[VAL_W-1:0];
			out_hit_q <= res_hit_q;
			out_st_q <= res_st_q;
			out_cnt_q <= cnt_wide[CNT_OUT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_cnt_q, out_rd_q};
	assign m_tuser = {out_st_q, out_hit_q};

	assign sts.mode = mode_t'(mode_q);
	assign sts.match = (rd_key == key_q);
	assign sts.last = (CW'(idx_q) + CW'(1)) == count_q;
	assign sts.shift_last = (CW'(idx_q) + CW'(2)) == count_q;
	assign sts.cnt_zero = (count_q == '0);
	assign sts.cnt_full = (count_q == CW'(CAPACITY));
	assign sts.out_free = !out_valid_q || m_tready;

endmodule

// File: src/linear_key_value_table_top.sv
// Flow: clear and unused modes go from decode straight to the result; a search probes one slot
// at a time (RAM read, then key compare) from slot 0 upward until a match or the last entry.
// Erase then moves each later entry down one slot; a miss probes every stored entry.
// Throughput: one word in flight; the next word is taken the cycle after the result is
// registered, while that result may still wait on m_tready.
// Reset: arst_n empties the table (count 0); stored entries are not cleared.
module linear_key_value_table_top
	import lkvt_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // key[31:0], value[63:32]
	input  logic [S_TUSER_W-1:0] s_tuser,  // mode[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // read_value[31:0], entry_count[38:32], pad[39]
	output logic [M_TUSER_W-1:0] m_tuser   // hit[0], status[2:1]
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	lkvt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lkvt_dp #(
		.CAPACITY  (CAPACITY),
		.KEY_BITS  (KEY_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule
